// File: sv/cpf_pkg.sv
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int NUM_CLASSES_DEF = 64;
  localparam int PROB_BITS       = 16;
  localparam int CLASS_BITS      = 6;
  localparam int WEIGHT_BITS     = 8;
  localparam int DIVISOR_BITS    = WEIGHT_BITS + 1;
  localparam int REM_BITS        = DIVISOR_BITS + 1;
  localparam int NUM_BITS        = PROB_BITS + WEIGHT_BITS + 1;
  localparam int STEP_BITS       = $clog2(NUM_BITS);

  localparam logic [WEIGHT_BITS-1:0] MAX_WEIGHT_RST = WEIGHT_BITS'(100);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE     = WEIGHT_BITS'(1);

  typedef struct packed {
    logic [CLASS_BITS-1:0] class_id;
    logic [PROB_BITS-1:0]  probability;
    logic                  last_in_set;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_BITS-1:0] best_class;
    logic [PROB_BITS-1:0]  best_probability;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

endpackage

// File: sv/class_probability_fusion.sv
`timescale 1ns / 1ps

// Fuses per-class Q1.15 probabilities into a running weighted average and
// reports the best class when a word marked last_in_set arrives. busy is
// high while a word is processed; start is taken only when busy is low.
// A class already present is updated through one shared restoring divider
// that retires one quotient bit per cycle; its steps are read, multiply,
// divide and write. A first sighting or an out-of-range id goes straight to
// the write. A last word adds a scan of every entry of the class memory at
// one entry per cycle. The result is on out_word for the single cycle that
// out_valid is high, in the cycle busy drops; there is no backpressure, so
// the receiver must take it then. No result is given when no class is
// present. max_weight is written through cfg_we / cfg_wdata; the user must
// write it only while busy is low, as the block does not enforce it.
module class_probability_fusion #(
  parameter int NUM_CLASSES = cpf_pkg::NUM_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cpf_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  output cpf_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [cpf_pkg::WEIGHT_BITS-1:0]   cfg_wdata
);

  localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(NUM_CLASSES + 1);
  localparam int PB    = cpf_pkg::PROB_BITS;
  localparam int WB    = cpf_pkg::WEIGHT_BITS;
  localparam int DB    = cpf_pkg::DIVISOR_BITS;
  localparam int RB    = cpf_pkg::REM_BITS;
  localparam int NB    = cpf_pkg::NUM_BITS;
  localparam int SB    = cpf_pkg::STEP_BITS;

  cpf_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]   id_r, id_nxt;
  logic [PB-1:0]      prob_r, prob_nxt;
  logic               last_r, last_nxt;
  logic               id_ok_r, id_ok_nxt;
  logic               first_r, first_nxt;
  logic [WB-1:0]      w_r, w_nxt;
  logic [NB-1:0]      num_r, num_nxt;
  logic [RB-1:0]      rem_r, rem_nxt;
  logic [DB-1:0]      div_r, div_nxt;
  logic [SB-1:0]      step_r, step_nxt;
  logic [CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_id_r, best_id_nxt;
  logic [PB-1:0]      best_p_r, best_p_nxt;
  logic [NUM_CLASSES-1:0] present_r, present_nxt;
  logic [WB-1:0]      max_weight_r;
  logic               out_valid_r, out_valid_nxt;
  cpf_pkg::out_word_t out_word_r, out_word_nxt;

  logic [PB-1:0]      prob_mem [NUM_CLASSES];
  logic [WB-1:0]      wt_mem [NUM_CLASSES];
  logic [PB-1:0]      rd_prob_r;
  logic [WB-1:0]      rd_wt_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [PB-1:0]      wr_prob;
  logic [WB-1:0]      wr_wt;

  logic [RB-1:0]      rem_sh;
  logic               rem_ge;
  logic [DB-1:0]      w_inc;
  logic               take;

  assign busy      = (state_r != cpf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign rem_sh = {rem_r[RB-2:0], num_r[NB-1]};
  assign rem_ge = (rem_sh >= RB'(div_r));
  assign w_inc  = DB'(w_r) + DB'(1);
  assign take   = rd_v_r && present_r[rd_idx_r] && (!found_r || (rd_prob_r >= best_p_r));

  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    prob_nxt      = prob_r;
    last_nxt      = last_r;
    id_ok_nxt     = id_ok_r;
    first_nxt     = first_r;
    w_nxt         = w_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    best_id_nxt   = best_id_r;
    best_p_nxt    = best_p_r;
    present_nxt   = present_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    rd_addr       = id_r;
    mem_we        = 1'b0;
    wr_prob       = prob_r;
    wr_wt         = cpf_pkg::WEIGHT_ONE;

    if (take) begin
      found_nxt   = 1'b1;
      best_id_nxt = rd_idx_r;
      best_p_nxt  = rd_prob_r;
    end

    case (state_r)
      cpf_pkg::ST_IDLE: begin
        if (start) begin
          id_nxt    = IDX_W'(in_word.class_id);
          prob_nxt  = in_word.probability;
          last_nxt  = in_word.last_in_set;
          id_ok_nxt = (32'(in_word.class_id) < NUM_CLASSES);
          first_nxt = 1'b1;
          if ((32'(in_word.class_id) < NUM_CLASSES) &&
              present_r[IDX_W'(in_word.class_id)]) begin
            first_nxt = 1'b0;
            state_nxt = cpf_pkg::ST_READ;
          end else begin
            state_nxt = cpf_pkg::ST_WRITE;
          end
        end
      end
      cpf_pkg::ST_READ: begin
        rd_addr   = id_r;
        state_nxt = cpf_pkg::ST_MUL;
      end
      cpf_pkg::ST_MUL: begin
        w_nxt     = rd_wt_r;
        num_nxt   = NB'(rd_prob_r) * NB'(rd_wt_r) + NB'(prob_r);
        div_nxt   = DB'(rd_wt_r) + DB'(1);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = cpf_pkg::ST_DIV;
      end
      cpf_pkg::ST_DIV: begin
        rem_nxt  = rem_ge ? (rem_sh - RB'(div_r)) : rem_sh;
        num_nxt  = {num_r[NB-2:0], rem_ge};
        step_nxt = step_r + SB'(1);
        if (step_r == SB'(NB - 1)) begin
          state_nxt = cpf_pkg::ST_WRITE;
        end
      end
      cpf_pkg::ST_WRITE: begin
        mem_we = id_ok_r;
        if (!first_r) begin
          wr_prob = num_r[PB-1:0];
          wr_wt   = (w_inc > DB'(max_weight_r)) ? max_weight_r : w_inc[WB-1:0];
        end
        if (id_ok_r) begin
          present_nxt[id_r] = 1'b1;
        end
        if (last_r) begin
          scan_cnt_nxt = '0;
          found_nxt    = 1'b0;
          state_nxt    = cpf_pkg::ST_SCAN;
        end else begin
          state_nxt = cpf_pkg::ST_IDLE;
        end
      end
      cpf_pkg::ST_SCAN: begin
        rd_addr      = scan_cnt_r[IDX_W-1:0];
        rd_v_nxt     = 1'b1;
        rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        if (scan_cnt_r == CNT_W'(NUM_CLASSES - 1)) begin
          state_nxt = cpf_pkg::ST_SCAN_END;
        end
      end
      cpf_pkg::ST_SCAN_END: begin
        out_valid_nxt                 = found_nxt;
        out_word_nxt.best_class       = cpf_pkg::CLASS_BITS'(best_id_nxt);
        out_word_nxt.best_probability = best_p_nxt;
        state_nxt                     = cpf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cpf_pkg::ST_IDLE;
      present_r    <= '0;
      max_weight_r <= cpf_pkg::MAX_WEIGHT_RST;
      out_valid_r  <= 1'b0;
      rd_v_r       <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      if (cfg_we) begin
        max_weight_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    prob_r     <= prob_nxt;
    last_r     <= last_nxt;
    id_ok_r    <= id_ok_nxt;
    first_r    <= first_nxt;
    w_r        <= w_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    step_r     <= step_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_p_r   <= best_p_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prob_mem[id_r] <= wr_prob;
      wt_mem[id_r]   <= wr_wt;
    end
    rd_prob_r <= prob_mem[rd_addr];
    rd_wt_r   <= wt_mem[rd_addr];
  end

endmodule

// File: sv/cpf_check.sv
`timescale 1ns / 1ps

module cpf_check (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind class_probability_fusion cpf_check u_cpf_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
